// File: rtl/core/ntps_pkg.sv
// shared types, codes and helpers of the neighbor table priority select unit
// no dependencies; used by ntps_front, ntps_engine and the top level
package ntps_pkg;

  // default sizes of the table and of the random fraction
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int RANDOM_BITS_DEF = 16;

  // fixed field widths
  localparam int ADDR_W = 48;
  localparam int RAND_W = 16;

  // decoded command of one input beat
  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_DELETE = 2'd1,
    OP_SELECT = 2'd2,
    OP_CLEAR  = 2'd3
  } op_kind_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_UPDATED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_SELECTED  = 3'd5,
    ST_CLEARED   = 3'd6
  } status_t;

  // one queued command
  typedef struct packed {
    op_kind_t          kind;
    logic [ADDR_W-1:0] address;
    logic              next_hop;
    logic              has_frames;
    logic [RAND_W-1:0] random_value;
  } op_t;

  // one table entry as kept in memory
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              next_hop;
    logic              has_frames;
  } entry_t;

  // priority class: 0 frames only, 1 next hop with frames, 2 next hop idle, 3 rest
  function automatic logic [1:0] entry_class(input logic nh, input logic hf);
    logic [1:0] c;
    if (!nh && hf) c = 2'd0;
    else if (nh && hf) c = 2'd1;
    else if (nh) c = 2'd2;
    else c = 2'd3;
    return c;
  endfunction

endpackage

// File: rtl/core/ntps_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module ntps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/ntps_front.sv
// front end: accepts input beats, decodes the command and queues it
// depends on ntps_pkg
module ntps_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_kind,
  input  logic [ntps_pkg::ADDR_W-1:0] in_address,
  input  logic                       in_next_hop,
  input  logic                       in_has_frames,
  input  logic [ntps_pkg::RAND_W-1:0] in_random_value,
  output logic                       op_valid,
  output ntps_pkg::op_t              op,
  input  logic                       op_pop
);

  ntps_pkg::op_t q_r [2];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    fill_r;
  logic [1:0]    fill_nxt;
  logic          push;
  ntps_pkg::op_t dec;

  // decode the command; flags only matter to an update
  always_comb begin
    dec.address      = in_address;
    dec.random_value = in_random_value;
    dec.next_hop     = 1'b0;
    dec.has_frames   = 1'b0;
    case (in_kind)
      ntps_pkg::OP_UPDATE: begin
        dec.kind       = ntps_pkg::OP_UPDATE;
        dec.next_hop   = in_next_hop;
        dec.has_frames = in_has_frames;
      end
      ntps_pkg::OP_DELETE: dec.kind = ntps_pkg::OP_DELETE;
      ntps_pkg::OP_SELECT: dec.kind = ntps_pkg::OP_SELECT;
      default: dec.kind = ntps_pkg::OP_CLEAR;
    endcase
  end

  assign busy     = (fill_r == 2'd2);
  assign push     = start && !busy;
  assign op_valid = (fill_r != 2'd0);
  assign op       = q_r[rd_ptr_r];

  // fill level of the two-entry queue
  always_comb begin
    fill_nxt = fill_r;
    if (push && !op_pop) fill_nxt = fill_r + 2'd1;
    else if (!push && op_pop) fill_nxt = fill_r - 2'd1;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (op_pop) rd_ptr_r <= !rd_ptr_r;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// File: rtl/core/ntps_engine.sv
// back end: runs queued commands against the table memory and drives results
// depends on ntps_pkg and ntps_ram
module ntps_engine #(
  parameter int TABLE_DEPTH = ntps_pkg::TABLE_DEPTH_DEF,
  parameter int RANDOM_BITS = ntps_pkg::RANDOM_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        op_valid,
  input  ntps_pkg::op_t               op,
  output logic                        op_pop,
  output logic                        out_valid,
  output logic [2:0]                  out_status,
  output logic [ntps_pkg::ADDR_W-1:0] out_selected_address,
  output logic                        out_is_broadcast,
  output logic [1:0]                  out_selected_class
);

  localparam int IW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int PROD_W = RANDOM_BITS + CNT_W;
  localparam int EW     = $bits(ntps_pkg::entry_t);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_UPD_SCAN  = 7'b0000010,
    S_DEL_SCAN  = 7'b0000100,
    S_DEL_SHIFT = 7'b0001000,
    S_SEL_COUNT = 7'b0010000,
    S_SEL_MUL   = 7'b0100000,
    S_SEL_SCAN  = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  ntps_pkg::op_t        op_r, op_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic                 pend_r, pend_nxt;
  logic [IW-1:0]        pend_idx_r, pend_idx_nxt;
  logic                 found_r, found_nxt;
  logic [CNT_W-1:0]     seen_r, seen_nxt;
  logic [CNT_W-1:0]     pick_r, pick_nxt;
  logic [1:0]           sel_cls_r, sel_cls_nxt;
  logic [CNT_W-1:0]     cls_cnt_r [4];
  logic [CNT_W-1:0]     cls_cnt_nxt [4];
  logic                 out_valid_r, out_valid_nxt;
  ntps_pkg::status_t    out_status_r, out_status_nxt;
  logic [ntps_pkg::ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic                 out_bcast_r, out_bcast_nxt;
  logic [1:0]           out_cls_r, out_cls_nxt;

  logic                 issue;
  logic                 can_read;
  logic                 scan_done;
  logic                 hit;
  logic                 wr_en;
  logic [IW-1:0]        waddr;
  ntps_pkg::entry_t     wdata;
  logic [EW-1:0]        rdata;
  ntps_pkg::entry_t     rd_entry;
  logic [1:0]           rd_cls;
  logic [1:0]           mul_cls;
  logic                 mul_any;
  logic [CNT_W-1:0]     mul_cnt;
  logic [RANDOM_BITS-1:0] rnd_m;
  logic [PROD_W-1:0]    prod;

  // table memory
  ntps_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rd_cnt_r[IW-1:0]),
    .rdata(rdata)
  );

  assign rd_entry  = ntps_pkg::entry_t'(rdata);
  assign rd_cls    = ntps_pkg::entry_class(rd_entry.next_hop, rd_entry.has_frames);
  assign can_read  = (rd_cnt_r != count_r);
  assign scan_done = !can_read && !pend_r;
  assign hit       = pend_r && (rd_entry.address == op_r.address);

  // lowest-numbered non-empty class and its scaled pick
  always_comb begin
    mul_cls = 2'd0;
    mul_any = 1'b0;
    for (int c = 3; c >= 0; c--) begin
      if (cls_cnt_r[c] != '0) begin
        mul_cls = 2'(c);
        mul_any = 1'b1;
      end
    end
    mul_cnt = cls_cnt_r[mul_cls];
    rnd_m   = RANDOM_BITS'(op_r.random_value);
    prod    = PROD_W'(rnd_m) * PROD_W'(mul_cnt);
  end

  // command sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    count_nxt      = count_r;
    rd_cnt_nxt     = rd_cnt_r;
    found_nxt      = found_r;
    seen_nxt       = seen_r;
    pick_nxt       = pick_r;
    sel_cls_nxt    = sel_cls_r;
    cls_cnt_nxt    = cls_cnt_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_bcast_nxt  = out_bcast_r;
    out_cls_nxt    = out_cls_r;
    op_pop         = 1'b0;
    issue          = 1'b0;
    wr_en          = 1'b0;
    waddr          = pend_idx_r;
    wdata.address    = op_r.address;
    wdata.next_hop   = op_r.next_hop;
    wdata.has_frames = op_r.has_frames;

    case (state_r)
      S_IDLE: begin
        if (op_valid) begin
          op_pop     = 1'b1;
          op_nxt     = op;
          rd_cnt_nxt = '0;
          found_nxt  = 1'b0;
          seen_nxt   = '0;
          for (int c = 0; c < 4; c++) cls_cnt_nxt[c] = '0;
          case (op.kind)
            ntps_pkg::OP_UPDATE: state_nxt = S_UPD_SCAN;
            ntps_pkg::OP_DELETE: state_nxt = S_DEL_SCAN;
            ntps_pkg::OP_SELECT: state_nxt = S_SEL_COUNT;
            ntps_pkg::OP_CLEAR: begin
              count_nxt      = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ntps_pkg::ST_CLEARED;
              out_addr_nxt   = '0;
              out_bcast_nxt  = 1'b0;
              out_cls_nxt    = 2'd0;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      // overwrite flags of every match, then insert if none matched and the table has room
      S_UPD_SCAN: begin
        issue = can_read;
        if (hit) begin
          wr_en     = 1'b1;
          found_nxt = 1'b1;
        end
        if (scan_done) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_addr_nxt  = '0;
          out_bcast_nxt = 1'b0;
          out_cls_nxt   = 2'd0;
          if (found_r) begin
            out_status_nxt = ntps_pkg::ST_UPDATED;
          end else if (count_r == CNT_W'(TABLE_DEPTH)) begin
            out_status_nxt = ntps_pkg::ST_FULL;
          end else begin
            wr_en          = 1'b1;
            waddr          = count_r[IW-1:0];
            count_nxt      = count_r + CNT_W'(1);
            out_status_nxt = ntps_pkg::ST_INSERTED;
          end
        end
      end

      // look for the first match; the read in flight starts the shift
      S_DEL_SCAN: begin
        issue = can_read;
        if (hit) begin
          state_nxt = S_DEL_SHIFT;
        end else if (scan_done) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ntps_pkg::ST_NOT_FOUND;
          out_addr_nxt   = '0;
          out_bcast_nxt  = 1'b0;
          out_cls_nxt    = 2'd0;
        end
      end

      // move each later entry down by one
      S_DEL_SHIFT: begin
        issue = can_read;
        if (pend_r) begin
          wr_en = 1'b1;
          waddr = pend_idx_r - IW'(1);
          wdata = rd_entry;
        end
        if (scan_done) begin
          state_nxt      = S_IDLE;
          count_nxt      = count_r - CNT_W'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = ntps_pkg::ST_DELETED;
          out_addr_nxt   = '0;
          out_bcast_nxt  = 1'b0;
          out_cls_nxt    = 2'd0;
        end
      end

      // count entries per class
      S_SEL_COUNT: begin
        issue = can_read;
        if (pend_r) begin
          cls_cnt_nxt[rd_cls] = cls_cnt_r[rd_cls] + CNT_W'(1);
        end
        if (scan_done) begin
          state_nxt = S_SEL_MUL;
        end
      end

      // scale the random fraction by the class size
      S_SEL_MUL: begin
        if (mul_any) begin
          pick_nxt    = prod[PROD_W-1:RANDOM_BITS];
          sel_cls_nxt = mul_cls;
          rd_cnt_nxt  = '0;
          state_nxt   = S_SEL_SCAN;
        end else begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ntps_pkg::ST_SELECTED;
          out_addr_nxt   = '1;
          out_bcast_nxt  = 1'b1;
          out_cls_nxt    = 2'd0;
        end
      end

      // walk the class members in table order up to the pick
      S_SEL_SCAN: begin
        issue = can_read;
        if (pend_r && (rd_cls == sel_cls_r)) begin
          if (seen_r == pick_r) begin
            issue          = 1'b0;
            state_nxt      = S_IDLE;
            out_valid_nxt  = 1'b1;
            out_status_nxt = ntps_pkg::ST_SELECTED;
            out_addr_nxt   = rd_entry.address;
            out_bcast_nxt  = 1'b0;
            out_cls_nxt    = sel_cls_r;
          end else begin
            seen_nxt = seen_r + CNT_W'(1);
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // read pipeline bookkeeping
    pend_nxt     = issue;
    pend_idx_nxt = rd_cnt_r[IW-1:0];
    if (issue) rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    rd_cnt_r     <= rd_cnt_nxt;
    pend_idx_r   <= pend_idx_nxt;
    found_r      <= found_nxt;
    seen_r       <= seen_nxt;
    pick_r       <= pick_nxt;
    sel_cls_r    <= sel_cls_nxt;
    cls_cnt_r    <= cls_cnt_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_bcast_r  <= out_bcast_nxt;
    out_cls_r    <= out_cls_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_selected_address = out_addr_r;
  assign out_is_broadcast     = out_bcast_r;
  assign out_selected_class   = out_cls_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (CNT_W'(waddr) <= count_r))
    else $error("table write beyond the end of the table");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    op_pop |-> (state_r == S_IDLE))
    else $error("command taken while another is running");

  a_pend_index: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (CNT_W'(pend_idx_r) + CNT_W'(1) == rd_cnt_r))
    else $error("read pipeline index out of step");

  a_delete_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ntps_pkg::ST_DELETED)
      |-> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("delete did not shrink the table by one");

endmodule

// File: rtl/core/neighbor_table_priority_select_unit.sv
// top level of the neighbor table priority select unit
// depends on ntps_pkg, ntps_front, ntps_engine (and ntps_ram below it)
//
//   channel   handshake            payload
//   input     start / busy         in_kind, in_address, in_next_hop,
//                                  in_has_frames, in_random_value
//   result    out_valid (strobe)   out_status, out_selected_address,
//                                  out_is_broadcast, out_selected_class
//
// a beat is taken when start is high and busy is low; a two-entry command queue
// lets up to two beats wait while one runs. one result per beat, held one cycle.
// clear does not read the table; update and delete walk it once, select twice (count,
// then pick), all through the single table read port; commands run one at a time.
// reset (rst_n low, synchronous) empties the table and the queue.
// results are never stalled; the receiver must take each strobed beat.
module neighbor_table_priority_select_unit #(
  parameter int TABLE_DEPTH = ntps_pkg::TABLE_DEPTH_DEF,
  parameter int RANDOM_BITS = ntps_pkg::RANDOM_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_kind,
  input  logic [ntps_pkg::ADDR_W-1:0] in_address,
  input  logic                        in_next_hop,
  input  logic                        in_has_frames,
  input  logic [ntps_pkg::RAND_W-1:0] in_random_value,
  output logic                        out_valid,
  output logic [2:0]                  out_status,
  output logic [ntps_pkg::ADDR_W-1:0] out_selected_address,
  output logic                        out_is_broadcast,
  output logic [1:0]                  out_selected_class
);

  logic          op_valid;
  logic          op_pop;
  ntps_pkg::op_t op;

  // accept and queue commands
  ntps_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_address     (in_address),
    .in_next_hop    (in_next_hop),
    .in_has_frames  (in_has_frames),
    .in_random_value(in_random_value),
    .op_valid       (op_valid),
    .op             (op),
    .op_pop         (op_pop)
  );

  // run commands on the table
  ntps_engine #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .RANDOM_BITS(RANDOM_BITS)
  ) u_engine (
    .clk                 (clk),
    .rst_n               (rst_n),
    .op_valid            (op_valid),
    .op                  (op),
    .op_pop              (op_pop),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_selected_address(out_selected_address),
    .out_is_broadcast    (out_is_broadcast),
    .out_selected_class  (out_selected_class)
  );

endmodule
